@@ hdl/leaky_recurrent_net_step_unit_macros.svh @@
// Assertion helpers used by the block's top module.
`ifndef LEAKY_RECURRENT_NET_STEP_UNIT_MACROS_SVH
`define LEAKY_RECURRENT_NET_STEP_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define LRN_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define LRN_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define LRN_ASSERT(label, clk, rst, prop)
`define LRN_ASSERT_RST(label, clk, prop)
`endif
`endif

@@ hdl/lrn_pkg.sv @@
package lrn_pkg;
  localparam int LAYERS_DEF       = 4;
  localparam int ACTIONS_DEF      = 4;
  localparam int SENSES_DEF       = 4;
  localparam int MEMORY_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int SENSE_FIELDS     = 4;
  localparam int ACTION_FIELDS    = 4;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_STEP   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_SQUASH, ST_MAC, ST_BIAS, ST_TAU, ST_DIV, ST_LEAK,
    ST_NEXT, ST_OUT
  } lrn_state_t;

  // Controller -> datapath
  typedef struct packed {
    logic sense_load;   // capture senses, start squash sweep
    logic squash_step;  // squash one memory entry
    logic mac_step;     // one weight times one activation
    logic acc_clear;
    logic bias_add;
    logic tau_load;     // latch tau, start divider
    logic div_step;
    logic leak_write;   // write new activation
    logic layer_swap;   // next layer's inputs become current
    logic clr_step;     // clear one prior entry (and all memory entries)
  } lrn_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic div_done;
  } lrn_stat_t;

  function automatic logic [15:0] squash_tab(input logic [5:0] i);
    case (i)
      6'd0: squash_tab = 16'd0;      6'd1: squash_tab = 16'd8150;
      6'd2: squash_tab = 16'd16051;  6'd3: squash_tab = 16'd23485;
      6'd4: squash_tab = 16'd30285;  6'd5: squash_tab = 16'd36346;
      6'd6: squash_tab = 16'd41625;  6'd7: squash_tab = 16'd46131;
      6'd8: squash_tab = 16'd49912;  6'd9: squash_tab = 16'd53038;
      6'd10: squash_tab = 16'd55593; 6'd11: squash_tab = 16'd57660;
      6'd12: squash_tab = 16'd59320; 6'd13: squash_tab = 16'd60643;
      6'd14: squash_tab = 16'd61694; 6'd15: squash_tab = 16'd62524;
      6'd16: squash_tab = 16'd63179; 6'd17: squash_tab = 16'd63693;
      6'd18: squash_tab = 16'd64096; 6'd19: squash_tab = 16'd64412;
      6'd20: squash_tab = 16'd64659; 6'd21: squash_tab = 16'd64852;
      6'd22: squash_tab = 16'd65003; 6'd23: squash_tab = 16'd65120;
      6'd24: squash_tab = 16'd65212; 6'd25: squash_tab = 16'd65283;
      6'd26: squash_tab = 16'd65339; 6'd27: squash_tab = 16'd65383;
      6'd28: squash_tab = 16'd65417; 6'd29: squash_tab = 16'd65443;
      6'd30: squash_tab = 16'd65464; 6'd31: squash_tab = 16'd65480;
      default: squash_tab = 16'd65492;
    endcase
  endfunction
endpackage

@@ hdl/lrn_ctrl.sv @@
module lrn_ctrl import lrn_pkg::*; #(
  parameter int LAYERS = LAYERS_DEF,
  parameter int NW     = ACTIONS_DEF + MEMORY_WIDTH_DEF,
  parameter int MEMW   = MEMORY_WIDTH_DEF,
  parameter int LW     = (LAYERS > 1) ? $clog2(LAYERS) : 1,
  parameter int NWB    = $clog2(NW + 1),
  parameter int MB     = $clog2(MEMW + 1),
  parameter int PB     = $clog2(LAYERS * NW + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start_step,
  input  logic            start_clear,
  input  logic            out_taken,
  input  lrn_stat_t       stat,
  output lrn_cmd_t        cmd,
  output logic            busy,
  output logic            out_valid,
  output logic [LW-1:0]   layer_idx,
  output logic [NWB-1:0]  neuron_idx,
  output logic [NWB-1:0]  input_idx,
  output logic [MB-1:0]   mem_idx,
  output logic [PB-1:0]   clr_idx
);
  lrn_state_t state, state_next;
  logic [LW-1:0]  layer_next;
  logic [NWB-1:0] neuron_next, input_next;
  logic [MB-1:0]  mem_next;
  logic [PB-1:0]  clr_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      layer_idx <= '0;
      neuron_idx <= '0;
      input_idx <= '0;
      mem_idx <= '0;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      layer_idx <= layer_next;
      neuron_idx <= neuron_next;
      input_idx <= input_next;
      mem_idx <= mem_next;
      clr_idx <= clr_next;
    end
  end

  always_comb begin
    state_next = state;
    layer_next = layer_idx;
    neuron_next = neuron_idx;
    input_next = input_idx;
    mem_next = mem_idx;
    clr_next = clr_idx;
    cmd = '0;
    out_valid = 1'b0;
    busy = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start_step) begin
          cmd.sense_load = 1'b1;
          mem_next = '0;
          state_next = ST_SQUASH;
        end else if (start_clear) begin
          clr_next = '0;
          state_next = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        clr_next = clr_idx + 1'b1;
        if (clr_idx == PB'(LAYERS * NW - 1)) state_next = ST_IDLE;
      end
      ST_SQUASH: begin
        cmd.squash_step = 1'b1;
        mem_next = mem_idx + 1'b1;
        if (mem_idx == MB'(MEMW - 1)) begin
          layer_next = '0;
          neuron_next = '0;
          input_next = '0;
          cmd.acc_clear = 1'b1;
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        cmd.mac_step = 1'b1;
        input_next = input_idx + 1'b1;
        if (input_idx == NWB'(NW - 1)) state_next = ST_BIAS;
      end
      ST_BIAS: begin
        cmd.bias_add = 1'b1;
        state_next = ST_TAU;
      end
      ST_TAU: begin
        cmd.tau_load = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_next = ST_LEAK;
      end
      ST_LEAK: begin
        cmd.leak_write = 1'b1;
        cmd.acc_clear = 1'b1;
        input_next = '0;
        if (neuron_idx == NWB'(NW - 1)) begin
          neuron_next = '0;
          state_next = ST_NEXT;
        end else begin
          neuron_next = neuron_idx + 1'b1;
          state_next = ST_MAC;
        end
      end
      ST_NEXT: begin
        cmd.layer_swap = 1'b1;
        if (layer_idx == LW'(LAYERS - 1)) begin
          state_next = ST_OUT;
        end else begin
          layer_next = layer_idx + 1'b1;
          state_next = ST_MAC;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_taken) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

@@ hdl/lrn_datapath.sv @@
module lrn_datapath import lrn_pkg::*; #(
  parameter int LAYERS = LAYERS_DEF,
  parameter int ACTIONS = ACTIONS_DEF,
  parameter int SENSES = SENSES_DEF,
  parameter int MEMW = MEMORY_WIDTH_DEF,
  parameter int FB = FRAC_BITS_DEF,
  parameter int NW = ACTIONS + MEMW,
  parameter int LW = (LAYERS > 1) ? $clog2(LAYERS) : 1,
  parameter int NWB = $clog2(NW + 1),
  parameter int MB = $clog2(MEMW + 1),
  parameter int PB = $clog2(LAYERS * NW + 1)
) (
  input  logic clk,
  input  logic rst,
  input  lrn_cmd_t cmd,
  output lrn_stat_t stat,
  input  logic [LW-1:0] layer_idx,
  input  logic [NWB-1:0] neuron_idx,
  input  logic [NWB-1:0] input_idx,
  input  logic [MB-1:0] mem_idx,
  input  logic [PB-1:0] clr_idx,
  input  logic wr_en,
  input  logic [1:0] wr_layer,
  input  logic [4:0] wr_neuron,
  input  logic [4:0] wr_slot,
  input  logic signed [31:0] wr_value,
  input  logic signed [31:0] sense [SENSE_FIELDS],
  output logic signed [31:0] action [ACTION_FIELDS]
);
  localparam int NDC = NW + 2;
  localparam int WDEPTH = LAYERS * NW * NDC;
  localparam int WA = $clog2(WDEPTH);
  localparam int PDEPTH = LAYERS * NW;
  localparam int PA = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
  localparam int NA = (NW > 1) ? $clog2(NW) : 1;
  localparam int MA = (MEMW > 1) ? $clog2(MEMW) : 1;
  localparam int SH = FB - 2;
  localparam int DB = FB + 34;   // dividend magnitude bits

  logic signed [31:0] wmem [WDEPTH];
  logic signed [31:0] pmem [PDEPTH];
  logic [PDEPTH-1:0] pvalid;
  logic signed [31:0] act [NW];
  logic signed [31:0] nxt [NW];
  logic signed [31:0] memv [MEMW];

  // Weight memory: one write port, one registered read port.
  logic [WA-1:0] rd_addr, wr_addr;
  logic signed [31:0] wdata;
  logic [4:0] rd_slot;
  always_comb begin
    rd_slot = 5'(input_idx);
    if (cmd.bias_add) rd_slot = 5'(NW + 1);
    if (cmd.tau_load) rd_slot = 5'(NW);
    rd_addr = WA'((32'(layer_idx) * NW + 32'(neuron_idx)) * NDC + 32'(rd_slot));
    wr_addr = WA'((32'(wr_layer) * NW + 32'(wr_neuron)) * NDC + 32'(wr_slot));
  end
  // Read address is the current one: no lookahead of the indices is used; a
  // register of the operand is used instead; the memory reads the current address
  // and the arithmetic consumes the read data in the next cycle.
  always_ff @(posedge clk) begin
    if (wr_en) wmem[wr_addr] <= wr_value;
    wdata <= wmem[rd_addr];
  end

  logic [PA-1:0] p_addr;
  assign p_addr = PA'(32'(layer_idx) * NW + 32'(neuron_idx));

  // Pipeline control: delayed copies of the command that uses wdata.
  logic mac_d, bias_d, tau_d;
  logic signed [31:0] opnd_d;
  always_ff @(posedge clk) begin
    if (rst) begin
      mac_d <= 1'b0; bias_d <= 1'b0; tau_d <= 1'b0;
    end else begin
      mac_d <= cmd.mac_step; bias_d <= cmd.bias_add; tau_d <= cmd.tau_load;
    end
    opnd_d <= act[NA'(input_idx)];
  end

  // Product registered before accumulation.
  logic signed [63:0] prod;
  logic prod_v;
  logic signed [55:0] acc;
  always_ff @(posedge clk) begin
    prod <= 64'(wdata) * 64'(opnd_d);
    if (rst) prod_v <= 1'b0;
    else prod_v <= mac_d;
  end

  logic signed [31:0] sum_sat, last, tau_r;
  always_comb begin
    if (acc > 56'sd2147483647) sum_sat = 32'sh7fffffff;
    else if (acc < -56'sd2147483648) sum_sat = 32'sh80000000;
    else sum_sat = acc[31:0];
  end

  // Restoring divider, one quotient bit per cycle.
  logic [DB-1:0] dvd, rem_q;
  logic [DB:0] rem;
  logic [32:0] dvs;
  logic [6:0] dcnt;
  logic qneg, div_run;
  logic [DB:0] trial;
  assign trial = {rem[DB-1:0], dvd[DB-1]} - (DB+1)'(dvs);
  assign stat.div_done = div_run && (dcnt == 7'd0);

  logic signed [33:0] diff;
  assign diff = 34'(sum_sat) - 34'(last);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      div_run <= 1'b0;
    end else begin
      // The last product and the bias land in the same cycle: add both.
      if (cmd.acc_clear) acc <= '0;
      else if (prod_v || bias_d)
        acc <= acc + (prod_v ? 56'(prod >>> FB) : 56'sd0)
                   + (bias_d ? 56'(wdata) : 56'sd0);
      if (tau_d) begin
        tau_r <= wdata[31] ? 32'sd0 : wdata;
        last <= pvalid[p_addr] ? pmem[p_addr] : 32'sd0;
        div_run <= 1'b0;
      end
      if (cmd.div_step && !div_run) begin
        // Hold off while tau and the prior activation are still loading.
        if (!tau_d) begin
          // Start: magnitude of (s - last) << FB over (1 << FB) + tau.
          dvd <= DB'(diff[33] ? -64'(diff) : 64'(diff)) << FB;
          qneg <= diff[33];
          dvs <= 33'(33'd1 << FB) + 33'(tau_r);
          rem <= '0;
          rem_q <= '0;
          dcnt <= 7'(DB);
          div_run <= 1'b1;
        end
      end else if (cmd.div_step && dcnt != 7'd0) begin
        if (!trial[DB]) begin
          rem <= trial;
          rem_q <= {rem_q[DB-2:0], 1'b1};
        end else begin
          rem <= {rem[DB-1:0], dvd[DB-1]};
          rem_q <= {rem_q[DB-2:0], 1'b0};
        end
        dvd <= dvd << 1;
        dcnt <= dcnt - 1'b1;
      end
      if (cmd.leak_write) div_run <= 1'b0;
    end
  end

  logic signed [DB+1:0] newv_w;
  logic signed [31:0] newv;
  always_comb begin
    newv_w = qneg ? -(DB+2)'(rem_q) : (DB+2)'(rem_q);
    newv_w = newv_w + (DB+2)'(last);
    if (newv_w > (DB+2)'(64'sh7fffffff)) newv = 32'sh7fffffff;
    else if (newv_w < -(DB+2)'(64'sh80000000)) newv = 32'sh80000000;
    else newv = newv_w[31:0];
  end

  // Prior activations: memory plus valid bits cleared at reset or clear.
  always_ff @(posedge clk) begin
    if (cmd.leak_write) pmem[p_addr] <= newv;
    if (cmd.leak_write) nxt[NA'(neuron_idx)] <= newv;
  end
  always_ff @(posedge clk) begin
    if (rst) pvalid <= '0;
    else if (cmd.clr_step) pvalid[PA'(clr_idx)] <= 1'b0;
    else if (cmd.leak_write) pvalid[p_addr] <= 1'b1;
  end

  // Squash of one memory entry.
  logic signed [31:0] mx;
  logic [31:0] mm, fr;
  logic [31:0] idx;
  logic [15:0] t0, t1;
  logic [47:0] ylin;
  logic [47:0] ysc;
  logic signed [31:0] sq;
  always_comb begin
    mx = memv[MA'(mem_idx)];
    mm = mx[31] ? 32'(-mx) : 32'(mx);
    idx = mm >> SH;
    fr = mm & ((32'd1 << SH) - 1);
    t0 = squash_tab(idx[5:0]);
    t1 = squash_tab(6'(idx[5:0] + 6'd1));
    if (idx >= 32) ylin = 48'(squash_tab(6'd32));
    else ylin = 48'(t0) + ((48'(t1 - t0) * 48'(fr)) >> SH);
    if (FB >= 16) ysc = ylin << (FB >= 16 ? FB - 16 : 0);
    else ysc = ylin >> (FB < 16 ? 16 - FB : 0);
    sq = mx[31] ? -32'(ysc) : 32'(ysc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MEMW; k++) memv[k] <= '0;
    end else begin
      if (cmd.clr_step) for (int k = 0; k < MEMW; k++) memv[k] <= '0;
      if (cmd.sense_load)
        for (int k = 0; k < NW; k++)
          act[k] <= (k < SENSES && k < SENSE_FIELDS) ? sense[k % SENSE_FIELDS] : 32'sd0;
      if (cmd.squash_step && (32'(mem_idx) + SENSES < NW))
        act[NA'(32'(mem_idx) + SENSES)] <= sq;
      if (cmd.layer_swap) begin
        for (int k = 0; k < NW; k++) act[k] <= nxt[k];
        if (layer_idx == LW'(LAYERS - 1))
          for (int k = 0; k < MEMW; k++)
            if (ACTIONS + k < NW) memv[k] <= nxt[(ACTIONS + k) % NW];
      end
    end
  end

  always_comb
    for (int k = 0; k < ACTION_FIELDS; k++)
      action[k] = (k < ACTIONS) ? act[k % NW] : 32'sd0;
endmodule

@@ hdl/leaky_recurrent_net_step_unit.sv @@
// Channel | Direction | Handshake           | Payload
// in      | into      | in_valid/in_stall   | op, layer, neuron, slot, param_value, sense0..3
// out     | out of    | out_valid/out_stall | action0..action3
// A load is taken without stalling and leaves the input free; a clear stalls
// the input while it sweeps the prior entries, one a cycle. A step runs the
// squash sweep over the memory entries, then per neuron the MAC sweep over NW
// inputs, bias, tau, the serial divider and the leak write, plus a layer swap
// per layer; most of a step's time is spent in the serial divider.
// Reset (rst, synchronous) clears memory, prior activations and the output.
// The input stalls while a step or clear runs, and while a finished step waits
// for the output register; a result holds there until its transfer.
`include "leaky_recurrent_net_step_unit_macros.svh"
module leaky_recurrent_net_step_unit import lrn_pkg::*; #(
  parameter int LAYERS = LAYERS_DEF,
  parameter int ACTIONS = ACTIONS_DEF,
  parameter int SENSES = SENSES_DEF,
  parameter int MEMORY_WIDTH = MEMORY_WIDTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] op,
  input  logic [1:0] layer,
  input  logic [4:0] neuron,
  input  logic [4:0] slot,
  input  logic signed [31:0] param_value,
  input  logic signed [31:0] sense0,
  input  logic signed [31:0] sense1,
  input  logic signed [31:0] sense2,
  input  logic signed [31:0] sense3,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [31:0] action0,
  output logic signed [31:0] action1,
  output logic signed [31:0] action2,
  output logic signed [31:0] action3
);
  localparam int NW = ACTIONS + MEMORY_WIDTH;
  localparam int LW = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int NWB = $clog2(NW + 1);
  localparam int MB = $clog2(MEMORY_WIDTH + 1);
  localparam int PB = $clog2(LAYERS * NW + 1);

  lrn_cmd_t cmd;
  lrn_stat_t stat;
  logic busy, acc_in, wr_en, res_valid, res_taken;
  logic [LW-1:0] layer_idx;
  logic [NWB-1:0] neuron_idx, input_idx;
  logic [MB-1:0] mem_idx;
  logic [PB-1:0] clr_idx;
  logic signed [31:0] sense [SENSE_FIELDS];
  logic signed [31:0] action [ACTION_FIELDS];

  // Transfer only when the controller is idle.
  assign in_stall = busy;
  assign acc_in = in_valid && !busy;
  // Drop loads that address past the parameter store.
  assign wr_en = acc_in && op == OP_LOAD && 32'(layer) < LAYERS
                 && 32'(neuron) < NW && 32'(slot) < NW + 2;
  assign sense[0] = sense0;
  assign sense[1] = sense1;
  assign sense[2] = sense2;
  assign sense[3] = sense3;

  // Output register: takes a finished step when empty or being emptied,
  // so the controller can go back to idle while the result waits.
  assign res_taken = !out_valid || !out_stall;
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (res_taken) out_valid <= res_valid;
    if (res_valid && res_taken) begin
      action0 <= action[0];
      action1 <= action[1];
      action2 <= action[2];
      action3 <= action[3];
    end
  end

  lrn_ctrl #(.LAYERS(LAYERS), .NW(NW), .MEMW(MEMORY_WIDTH)) u_ctrl (
    .clk, .rst,
    .start_step(acc_in && op == OP_STEP),
    .start_clear(acc_in && op == OP_CLEAR),
    .out_taken(res_taken), .stat, .cmd, .busy, .out_valid(res_valid),
    .layer_idx, .neuron_idx, .input_idx, .mem_idx, .clr_idx
  );

  lrn_datapath #(.LAYERS(LAYERS), .ACTIONS(ACTIONS), .SENSES(SENSES),
                 .MEMW(MEMORY_WIDTH), .FB(FRAC_BITS)) u_dp (
    .clk, .rst, .cmd, .stat, .layer_idx, .neuron_idx, .input_idx, .mem_idx,
    .clr_idx, .wr_en, .wr_layer(layer), .wr_neuron(neuron), .wr_slot(slot),
    .wr_value(param_value), .sense, .action
  );

  `LRN_ASSERT(a_load_idle, clk, rst, acc_in && op == OP_LOAD |=> !in_stall)
  `LRN_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(action0))
  `LRN_ASSERT_RST(a_rst_idle, clk, $past(rst) |-> !out_valid)
endmodule
